@@ rtl/swpd_pkg.sv @@
// ----------------------------------------------------------------------------
// swpd_pkg
// Shared types, register map and color tables for the screen word decoder.
// ----------------------------------------------------------------------------
package swpd_pkg;

  localparam int AddrW   = 20;
  localparam int WordW   = 16;
  localparam int PixW    = 8;
  localparam int XW      = 9;
  localparam int YW      = 8;
  localparam int PaddrW  = 4;
  localparam int PdataW  = 32;
  localparam int RegIdxW = 2;

  // register indexes (byte address = 4 * index)
  localparam logic [RegIdxW-1:0] REG_SCREEN_MODE = 2'd0;
  localparam logic [RegIdxW-1:0] REG_REFRESH_DIS = 2'd1;
  localparam logic [RegIdxW-1:0] REG_DEBUG_ACT   = 2'd2;

  localparam logic [AddrW-1:0] BANK_SPLIT = 20'h28000;
  localparam int MODE_BANK_BIT  = 7;
  localparam int MODE_EIGHT_BIT = 3;

  typedef struct packed {
    logic [AddrW-1:0] byte_address;
    logic [WordW-1:0] data_word;
  } swpd_in_t;

  typedef struct packed {
    logic            drawn;
    logic [XW-1:0]   x_pos;
    logic [YW-1:0]   y_pos;
    logic [PixW-1:0] pix0;
    logic [PixW-1:0] pix1;
    logic [PixW-1:0] pix2;
    logic [PixW-1:0] pix3;
    logic [PixW-1:0] pix4;
    logic [PixW-1:0] pix5;
    logic [PixW-1:0] pix6;
    logic [PixW-1:0] pix7;
  } swpd_out_t;

  function automatic logic [PixW-1:0] four_colour_lut(input logic [1:0] code);
    logic [PixW-1:0] c;
    case (code)
      2'd0:    c = 8'd0;
      2'd1:    c = 8'd249;
      2'd2:    c = 8'd250;
      2'd3:    c = 8'd255;
      default: c = 8'd0;
    endcase
    return c;
  endfunction

  function automatic logic [PixW-1:0] eight_colour_lut(input logic [3:0] code);
    logic [PixW-1:0] c;
    case (code)
      4'd0:    c = 8'd0;
      4'd1:    c = 8'd252;
      4'd2:    c = 8'd249;
      4'd3:    c = 8'd253;
      4'd4:    c = 8'd250;
      4'd5:    c = 8'd253;
      4'd6:    c = 8'd254;
      4'd7:    c = 8'd255;
      4'd8:    c = 8'd250;
      4'd9:    c = 8'd254;
      4'd10:   c = 8'd251;
      4'd11:   c = 8'd255;
      4'd12:   c = 8'd0;
      4'd13:   c = 8'd252;
      4'd14:   c = 8'd249;
      4'd15:   c = 8'd251;
      default: c = 8'd0;
    endcase
    return c;
  endfunction

endpackage

@@ rtl/screen_word_pixel_decoder.sv @@
// ----------------------------------------------------------------------------
// screen_word_pixel_decoder
// Decodes one screen memory write into a row, a column and eight pixels.
// ----------------------------------------------------------------------------
//  channel | direction | handshake          | payload
//  in_     | input     | in_valid/in_ready  | in_data  (swpd_in_t)
//  out_    | output    | out_valid/out_ready| out_data (swpd_out_t)
//  cfg     | input     | APB psel/penable   | paddr/pwdata/prdata
//
//  One transfer per cycle unless stalled; a result shows in the next cycle.
//  The only storage on the data path is the result register; a new input is
//  taken whenever that register is empty or is emptied in the same cycle.
//  rst_n (synchronous) clears out_valid and all config registers.
//  A stalled output holds the result and stalls the input.
// ----------------------------------------------------------------------------
module screen_word_pixel_decoder (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  swpd_pkg::swpd_in_t        in_data,
  output logic                      out_valid,
  input  logic                      out_ready,
  output swpd_pkg::swpd_out_t       out_data,
  input  logic                      psel,
  input  logic                      penable,
  input  logic                      pwrite,
  input  logic [swpd_pkg::PaddrW-1:0] paddr,
  input  logic [swpd_pkg::PdataW-1:0] pwdata,
  output logic [swpd_pkg::PdataW-1:0] prdata,
  output logic                      pready
);

  logic [7:0] screen_mode_r;
  logic       refresh_dis_r;
  logic       debug_act_r;
  logic       out_valid_r;
  swpd_pkg::swpd_out_t out_data_r;
  swpd_pkg::swpd_out_t res_nxt;

  logic [swpd_pkg::RegIdxW-1:0] reg_idx;
  logic                         cfg_wr;
  logic                         in_xfer;

  assign pready  = 1'b1;
  assign reg_idx = paddr[swpd_pkg::PaddrW-1:2];
  assign cfg_wr  = psel & penable & pwrite & pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      screen_mode_r <= '0;
      refresh_dis_r <= 1'b0;
      debug_act_r   <= 1'b0;
    end else if (cfg_wr) begin
      case (reg_idx)
        swpd_pkg::REG_SCREEN_MODE: screen_mode_r <= pwdata[7:0];
        swpd_pkg::REG_REFRESH_DIS: refresh_dis_r <= pwdata[0];
        swpd_pkg::REG_DEBUG_ACT:   debug_act_r   <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      swpd_pkg::REG_SCREEN_MODE: prdata = {24'd0, screen_mode_r};
      swpd_pkg::REG_REFRESH_DIS: prdata = {31'd0, refresh_dis_r};
      swpd_pkg::REG_DEBUG_ACT:   prdata = {31'd0, debug_act_r};
      default:                   prdata = '0;
    endcase
  end

  // decode
  always_comb begin
    logic [7:0]  hi;
    logic [7:0]  lo;
    logic [14:0] offset;
    logic        upper;
    logic        draw;
    logic [swpd_pkg::PixW-1:0] pix [8];

    hi     = in_data.data_word[15:8];
    lo     = in_data.data_word[7:0];
    offset = in_data.byte_address[14:0];
    upper  = (in_data.byte_address >= swpd_pkg::BANK_SPLIT);
    draw   = !refresh_dis_r && !debug_act_r &&
             (upper == screen_mode_r[swpd_pkg::MODE_BANK_BIT]);

    for (int k = 0; k < 8; k++) begin
      if (screen_mode_r[swpd_pkg::MODE_EIGHT_BIT]) begin
        // pixel pairs share one 4-bit code, two bits from each byte
        pix[k] = swpd_pkg::eight_colour_lut({hi[7-2*(k/2)], hi[6-2*(k/2)],
                                             lo[7-2*(k/2)], lo[6-2*(k/2)]});
      end else begin
        pix[k] = swpd_pkg::four_colour_lut({hi[7-k], lo[7-k]});
      end
    end

    res_nxt = '0;
    if (draw) begin
      res_nxt.drawn = 1'b1;
      res_nxt.x_pos = {offset[6:0], 2'b00};
      res_nxt.y_pos = offset[14:7];
      res_nxt.pix0  = pix[0];
      res_nxt.pix1  = pix[1];
      res_nxt.pix2  = pix[2];
      res_nxt.pix3  = pix[3];
      res_nxt.pix4  = pix[4];
      res_nxt.pix5  = pix[5];
      res_nxt.pix6  = pix[6];
      res_nxt.pix7  = pix[7];
    end
  end

  assign in_ready = !out_valid_r || out_ready;
  assign in_xfer  = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_ready) begin
      out_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      out_data_r <= res_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

@@ rtl/swpd_checker.sv @@
// ----------------------------------------------------------------------------
// swpd_checker
// Port-level checks for the screen word decoder, bound to the top level.
// ----------------------------------------------------------------------------
module swpd_checker (
  input logic                clk,
  input logic                rst_n,
  input logic                in_valid,
  input logic                in_ready,
  input logic                out_valid,
  input logic                out_ready,
  input swpd_pkg::swpd_out_t out_data
);

  // a transfer in always yields a result in the next cycle
  a_in_to_out: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> out_valid)
    else $error("input transfer produced no result");

  // empty output register never blocks the input
  a_ready_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> in_ready)
    else $error("input stalled with empty output");

  // dropped writes carry all-zero fields; position, pix0, pix3 and pix7 are checked
  a_drop_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.drawn |->
      out_data.x_pos == '0 && out_data.y_pos == '0 && out_data.pix0 == '0 &&
      out_data.pix3 == '0 && out_data.pix7 == '0)
    else $error("dropped write with nonzero fields");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("stalled result changed");

endmodule

bind screen_word_pixel_decoder swpd_checker u_swpd_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);

@@ tb/screen_word_pixel_decoder_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// screen_word_pixel_decoder_tb
// Drives screen memory writes through the decoder under a range of mode,
// refresh and debug settings. Each result is checked field by field against
// a local decode of the same write, with random input bursts and output
// stalls.
// ----------------------------------------------------------------------------
module screen_word_pixel_decoder_tb;

  localparam int StallLimit = 2000;
  localparam int NumSettings = 11;
  localparam int WordsPerSetting = 58;
  localparam logic [swpd_pkg::RegIdxW-1:0] REG_UNUSED = 2'd3;

  localparam logic [swpd_pkg::PixW-1:0] FOUR_TAB [4] = '{8'd0, 8'd249, 8'd250, 8'd255};
  localparam logic [swpd_pkg::PixW-1:0] EIGHT_TAB [16] = '{
    8'd0, 8'd252, 8'd249, 8'd253, 8'd250, 8'd253, 8'd254, 8'd255,
    8'd250, 8'd254, 8'd251, 8'd255, 8'd0, 8'd252, 8'd249, 8'd251
  };

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic                in_valid = 1'b0;
  logic                in_ready;
  swpd_pkg::swpd_in_t  in_data = '0;
  logic                out_valid;
  logic                out_ready = 1'b0;
  swpd_pkg::swpd_out_t out_data;

  logic                        psel = 1'b0;
  logic                        penable = 1'b0;
  logic                        pwrite = 1'b0;
  logic [swpd_pkg::PaddrW-1:0] paddr = '0;
  logic [swpd_pkg::PdataW-1:0] pwdata = '0;
  logic [swpd_pkg::PdataW-1:0] prdata;
  logic                        pready;

  // local copy of the config registers
  logic [7:0] mode_m = 8'd0;
  logic       refresh_off_m = 1'b0;
  logic       debug_on_m = 1'b0;

  swpd_pkg::swpd_in_t  pending_writes[$];
  swpd_pkg::swpd_out_t predicted_pixels[$];
  swpd_pkg::swpd_out_t want;

  int burst_left = 1;
  int gap_left = 0;
  logic [15:0] ready_pat = 16'hffff;
  logic [15:0] ready_nxt;
  logic [5:0]  stall_tick = '0;
  int stall_cycles = 0;
  int mismatches = 0;
  int words_checked = 0;
  int words_drawn = 0;

  screen_word_pixel_decoder dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always #5 clk = ~clk;

  function automatic swpd_pkg::swpd_out_t decode_screen_word(swpd_pkg::swpd_in_t w);
    swpd_pkg::swpd_out_t r;
    logic [14:0] off;
    logic [7:0] hi;
    logic [7:0] lo;
    logic [swpd_pkg::PixW-1:0] px [8];
    logic [3:0] code;
    int k;
    r = '0;
    if (refresh_off_m || debug_on_m ||
        ((w.byte_address >= swpd_pkg::BANK_SPLIT) != mode_m[swpd_pkg::MODE_BANK_BIT]))
      return r;
    off = w.byte_address[14:0];
    hi = w.data_word[15:8];
    lo = w.data_word[7:0];
    r.drawn = 1'b1;
    r.x_pos = {off[6:0], 2'b00};
    r.y_pos = off[14:7];
    if (!mode_m[swpd_pkg::MODE_EIGHT_BIT]) begin
      for (k = 0; k < 8; k++)
        px[k] = FOUR_TAB[{hi[7-k], lo[7-k]}];
    end else begin
      // two bits per byte per pixel pair, each pixel doubled
      for (k = 0; k < 4; k++) begin
        code = {hi[7-2*k -: 2], lo[7-2*k -: 2]};
        px[2*k] = EIGHT_TAB[code];
        px[2*k+1] = EIGHT_TAB[code];
      end
    end
    r.pix0 = px[0]; r.pix1 = px[1]; r.pix2 = px[2]; r.pix3 = px[3];
    r.pix4 = px[4]; r.pix5 = px[5]; r.pix6 = px[6]; r.pix7 = px[7];
    return r;
  endfunction

  task automatic check_field(string name, logic [31:0] exp_v, logic [31:0] act_v);
    if (exp_v !== act_v) begin
      $error("%s mismatch: expected %0d, got %0d", name, exp_v, act_v);
      mismatches++;
    end
  endtask

  // sender: bursts of random length separated by random gaps
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_ready) begin
      if (gap_left > 0) begin
        gap_left <= gap_left - 1;
        in_valid <= 1'b0;
      end else if (pending_writes.size() > 0) begin
        in_data <= pending_writes.pop_front();
        in_valid <= 1'b1;
        if (burst_left <= 1) begin
          burst_left <= int'($urandom_range(1, 24));
          gap_left <= ($urandom_range(0, 3) == 0) ? 0 : int'($urandom_range(1, 6));
        end else begin
          burst_left <= burst_left - 1;
        end
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // receiver: rotating stall mask, reshuffled whenever the 6-bit tick counter wraps
  always @(posedge clk) begin
    ready_nxt = ready_pat;
    if (stall_tick == 6'd0) begin
      if ($urandom_range(0, 3) == 0)
        ready_nxt = 16'hffff;
      else
        ready_nxt = 16'($urandom) | 16'h0001;
    end
    out_ready <= ready_nxt[0];
    ready_pat <= {ready_nxt[0], ready_nxt[15:1]};
    stall_tick <= stall_tick + 6'd1;
  end

  // monitor: predict on each input transfer, check each output transfer
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && in_ready)
        predicted_pixels.push_back(decode_screen_word(in_data));
      if (out_valid && out_ready) begin
        if (predicted_pixels.size() == 0) begin
          $error("unexpected result transfer: %p", out_data);
          mismatches++;
        end else begin
          want = predicted_pixels.pop_front();
          check_field("drawn", 32'(want.drawn), 32'(out_data.drawn));
          check_field("x_pos", 32'(want.x_pos), 32'(out_data.x_pos));
          check_field("y_pos", 32'(want.y_pos), 32'(out_data.y_pos));
          check_field("pix0", 32'(want.pix0), 32'(out_data.pix0));
          check_field("pix1", 32'(want.pix1), 32'(out_data.pix1));
          check_field("pix2", 32'(want.pix2), 32'(out_data.pix2));
          check_field("pix3", 32'(want.pix3), 32'(out_data.pix3));
          check_field("pix4", 32'(want.pix4), 32'(out_data.pix4));
          check_field("pix5", 32'(want.pix5), 32'(out_data.pix5));
          check_field("pix6", 32'(want.pix6), 32'(out_data.pix6));
          check_field("pix7", 32'(want.pix7), 32'(out_data.pix7));
          words_checked++;
          if (want.drawn)
            words_drawn++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
      if (stall_cycles >= StallLimit) begin
        $display("Some tests failed");
        $finish;
      end
    end
  end

  task automatic write_reg(logic [swpd_pkg::RegIdxW-1:0] idx, logic [31:0] value);
    @(posedge clk);
    psel <= 1'b1;
    pwrite <= 1'b1;
    penable <= 1'b0;
    paddr <= swpd_pkg::PaddrW'(4 * idx);
    pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    // register takes the value at this edge
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    case (idx)
      swpd_pkg::REG_SCREEN_MODE: mode_m = value[7:0];
      swpd_pkg::REG_REFRESH_DIS: refresh_off_m = value[0];
      swpd_pkg::REG_DEBUG_ACT:   debug_on_m = value[0];
      default: ;
    endcase
  endtask

  task automatic wait_idle();
    @(negedge clk);
    while (pending_writes.size() != 0 || in_valid || predicted_pixels.size() != 0)
      @(negedge clk);
    repeat (2) @(negedge clk);
  endtask

  task automatic queue_write(logic [swpd_pkg::AddrW-1:0] a,
                             logic [swpd_pkg::WordW-1:0] d);
    swpd_pkg::swpd_in_t w;
    w.byte_address = a;
    w.data_word = d;
    pending_writes.push_back(w);
  endtask

  task automatic queue_random(int n);
    logic [swpd_pkg::AddrW-1:0] lower_a;
    logic [swpd_pkg::AddrW-1:0] upper_a;
    logic [swpd_pkg::AddrW-1:0] a;
    int r;
    for (int i = 0; i < n; i++) begin
      lower_a = 20'($urandom_range(0, 20'h27fff));
      upper_a = 20'($urandom_range(20'h28000, 20'hfffff));
      r = int'($urandom_range(0, 9));
      // mostly the shown bank, some the hidden one, a few around the split
      if (r < 6)
        a = mode_m[swpd_pkg::MODE_BANK_BIT] ? upper_a : lower_a;
      else if (r < 8)
        a = mode_m[swpd_pkg::MODE_BANK_BIT] ? lower_a : upper_a;
      else
        a = 20'($urandom_range(20'h27fc0, 20'h2803f));
      queue_write(a, 16'($urandom));
    end
  endtask

  initial begin : stimulus
    logic [7:0] mode_set [NumSettings];
    logic refresh_set [NumSettings];
    logic debug_set [NumSettings];
    logic [31:0] v;
    mode_set = '{8'h00, 8'h80, 8'h08, 8'h88, 8'hff, 8'h77, 8'h88, 8'h08, 8'h80,
                 8'h00, 8'h00};
    refresh_set = '{1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b1, 1'b0, 1'b1, 1'b0, 1'b0};
    debug_set   = '{1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b1, 1'b1, 1'b0, 1'b0};

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    // reset settings: lower bank shown, 4-color
    @(negedge clk);
    queue_write(20'h00000, 16'h0000);
    queue_write(20'h00000, 16'hffff);
    queue_write(20'h27fff, 16'hccaa);   // every 4-color code
    queue_write(20'h07fff, 16'h3355);   // last column, last row
    queue_write(20'h00080, 16'haa55);
    queue_write(20'h28000, 16'hffff);   // hidden bank
    queue_write(20'hfffff, 16'h1234);
    queue_write(20'h1ffff, 16'h8001);
    wait_idle();

    // write to an address past the register list must change nothing
    write_reg(REG_UNUSED, 32'hffff_ffff);
    write_reg(swpd_pkg::REG_SCREEN_MODE, 32'h0000_0088);
    @(negedge clk);
    // upper bank, 8-color: cover all sixteen codes
    queue_write(20'h28000, 16'h1b00);
    queue_write(20'hfffff, 16'h1b55);
    queue_write(20'h2ffff, 16'h1baa);
    queue_write(20'h2f001, 16'h1bff);
    queue_write(20'h27fff, 16'hffff);   // hidden bank
    queue_write(20'h00000, 16'h0000);   // hidden bank
    wait_idle();

    for (int s = 0; s < NumSettings; s++) begin
      v = $urandom;
      v[7:0] = (s == 9) ? 8'($urandom) : mode_set[s];
      write_reg(swpd_pkg::REG_SCREEN_MODE, v);
      v = $urandom;
      v[0] = refresh_set[s];
      write_reg(swpd_pkg::REG_REFRESH_DIS, v);
      v = $urandom;
      v[0] = debug_set[s];
      write_reg(swpd_pkg::REG_DEBUG_ACT, v);
      @(negedge clk);
      queue_random(WordsPerSetting);
      wait_idle();
    end

    repeat (5) @(posedge clk);
    $display("Checked %0d screen writes (%0d drawn) across %0d register settings",
             words_checked, words_drawn, NumSettings + 2);
    if (mismatches == 0 && predicted_pixels.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
